// ----- rtl/core/wrp_pkg.sv -----
package wrp_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_HALT   = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_PCM    = 2'd1;
    localparam logic [1:0] KIND_CHANGE = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Tags, first stream byte in the low bits
    localparam logic [31:0] RIFF_WORD = 32'h4646_4952;
    localparam logic [31:0] WAVE_WORD = 32'h4556_4157;
    localparam logic [31:0] ID_DATA   = 32'h6174_6164;
    localparam logic [31:0] ID_FMT    = 32'h2074_6D66;

    // Byte positions in the stream header and the fmt body
    localparam logic [3:0] HEADER_LAST = 4'd11;
    localparam logic [3:0] WAVE_FIRST  = 4'd8;
    localparam logic [3:0] RIFF_END    = 4'd4;
    localparam logic [3:0] FMT_LEN     = 4'd8;
    localparam logic [3:0] FIELD_LAST  = 4'd3;

    localparam logic [31:0] RATE_RESET = 32'd16000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pcm_byte;
        logic        chunk_end;
        logic [31:0] new_rate;
        logic [15:0] new_channels;
    } wrp_result_t;

endpackage

// ----- rtl/core/wrp_parse_core.sv -----
module wrp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 accept,
    input  logic                 restart,
    input  logic [7:0]           data_byte,
    output wrp_pkg::wrp_result_t result
);
    import wrp_pkg::*;

    logic [31:0] expected_rate_reg;
    logic [2:0]  phase_reg,       phase_next;
    logic [3:0]  count_reg,       count_next;
    logic        hdr_bad_reg,     hdr_bad_next;
    logic [31:0] chunk_id_reg,    chunk_id_next;
    logic [31:0] size_reg,        size_next;
    logic [31:0] bytes_left_reg,  bytes_left_next;
    logic        in_fmt_reg,      in_fmt_next;
    logic [3:0]  fmt_index_reg,   fmt_index_next;
    logic [15:0] fmt_chan_reg,    fmt_chan_next;
    logic [23:0] fmt_rate_reg,    fmt_rate_next;
    logic [31:0] stream_rate_reg, stream_rate_next;
    logic [15:0] stream_chan_reg, stream_chan_next;

    logic        tag_bad;
    logic        bad_acc;
    logic [31:0] size_full;
    logic [31:0] left_dec;

    // Compare header bytes against the tags as they arrive
    always_comb
    begin
        tag_bad = 1'b0;
        if (count_reg < RIFF_END)
        begin
            tag_bad = (data_byte != RIFF_WORD[{count_reg[1:0], 3'b000} +: 8]);
        end
        else if (count_reg >= WAVE_FIRST)
        begin
            tag_bad = (data_byte != WAVE_WORD[{count_reg[1:0], 3'b000} +: 8]);
        end
        bad_acc   = hdr_bad_reg | tag_bad;
        size_full = {data_byte, size_reg[31:8]};
        left_dec  = (bytes_left_reg != 32'd0) ? (bytes_left_reg - 32'd1) : 32'd0;
    end

    // Advance the parser by one word
    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        hdr_bad_next     = hdr_bad_reg;
        chunk_id_next    = chunk_id_reg;
        size_next        = size_reg;
        bytes_left_next  = bytes_left_reg;
        in_fmt_next      = in_fmt_reg;
        fmt_index_next   = fmt_index_reg;
        fmt_chan_next    = fmt_chan_reg;
        fmt_rate_next    = fmt_rate_reg;
        stream_rate_next = stream_rate_reg;
        stream_chan_next = stream_chan_reg;
        result           = '0;

        if (restart)
        begin
            phase_next       = PH_HEADER;
            count_next       = 4'd0;
            hdr_bad_next     = 1'b0;
            bytes_left_next  = 32'd0;
            in_fmt_next      = 1'b0;
            fmt_index_next   = 4'd0;
            stream_rate_next = 32'd0;
            stream_chan_next = 16'd0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (count_reg == HEADER_LAST)
                    begin
                        count_next   = 4'd0;
                        hdr_bad_next = 1'b0;
                        if (bad_acc)
                        begin
                            result.kind = KIND_ERROR;
                            phase_next  = PH_HALT;
                        end
                        else
                        begin
                            phase_next = PH_ID;
                        end
                    end
                    else
                    begin
                        count_next   = count_reg + 4'd1;
                        hdr_bad_next = bad_acc;
                    end
                end
                PH_ID:
                begin
                    chunk_id_next = {data_byte, chunk_id_reg[31:8]};
                    if (count_reg == FIELD_LAST)
                    begin
                        count_next = 4'd0;
                        phase_next = PH_SIZE;
                    end
                    else
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end
                PH_SIZE:
                begin
                    size_next = size_full;
                    if (count_reg == FIELD_LAST)
                    begin
                        count_next = 4'd0;
                        if (chunk_id_reg == ID_DATA)
                        begin
                            bytes_left_next = size_full;
                            phase_next      = PH_DATA;
                            if (stream_rate_reg != 32'd0 &&
                                stream_rate_reg != expected_rate_reg)
                            begin
                                result.kind         = KIND_CHANGE;
                                result.new_rate     = stream_rate_reg;
                                result.new_channels = (stream_chan_reg != 16'd0) ?
                                                      stream_chan_reg : 16'd1;
                            end
                        end
                        else
                        begin
                            in_fmt_next     = (chunk_id_reg == ID_FMT);
                            fmt_index_next  = 4'd0;
                            // pad odd sizes; wraps at the top of range
                            bytes_left_next = size_full + {31'd0, size_full[0]};
                            phase_next      = PH_SKIP;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 4'd1;
                    end
                end
                PH_SKIP:
                begin
                    if (in_fmt_reg && fmt_index_reg < FMT_LEN)
                    begin
                        fmt_index_next = fmt_index_reg + 4'd1;
                        case (fmt_index_reg)
                            4'd2:    fmt_chan_next[7:0]   = data_byte;
                            4'd3:    fmt_chan_next[15:8]  = data_byte;
                            4'd4:    fmt_rate_next[7:0]   = data_byte;
                            4'd5:    fmt_rate_next[15:8]  = data_byte;
                            4'd6:    fmt_rate_next[23:16] = data_byte;
                            4'd7:
                            begin
                                stream_chan_next = fmt_chan_reg;
                                stream_rate_next = {data_byte, fmt_rate_reg};
                            end
                            default: ;
                        endcase
                    end
                    bytes_left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        in_fmt_next = 1'b0;
                        phase_next  = PH_ID;
                    end
                end
                PH_DATA:
                begin
                    result.kind     = KIND_PCM;
                    result.pcm_byte = data_byte;
                    bytes_left_next = left_dec;
                    if (left_dec == 32'd0)
                    begin
                        result.chunk_end = 1'b1;
                        phase_next       = PH_ID;
                    end
                end
                default:
                begin
                    // hold until restart
                end
            endcase
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rate_reg <= RATE_RESET;
        end
        else if (cfg_wr_en)
        begin
            expected_rate_reg <= cfg_wr_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            count_reg       <= 4'd0;
            hdr_bad_reg     <= 1'b0;
            bytes_left_reg  <= 32'd0;
            in_fmt_reg      <= 1'b0;
            fmt_index_reg   <= 4'd0;
            stream_rate_reg <= 32'd0;
            stream_chan_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            hdr_bad_reg     <= hdr_bad_next;
            bytes_left_reg  <= bytes_left_next;
            in_fmt_reg      <= in_fmt_next;
            fmt_index_reg   <= fmt_index_next;
            stream_rate_reg <= stream_rate_next;
            stream_chan_reg <= stream_chan_next;
        end
    end

    // Shift registers for id, size and fmt fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            chunk_id_reg <= chunk_id_next;
            size_reg     <= size_next;
            fmt_chan_reg <= fmt_chan_next;
            fmt_rate_reg <= fmt_rate_next;
        end
    end

endmodule

// ----- rtl/core/wrp_out_stage.sv -----
module wrp_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wrp_pkg::wrp_result_t in_result,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wrp_pkg::wrp_result_t out_result
);
    import wrp_pkg::*;

    logic        valid_reg;
    wrp_result_t result_reg;

    // Take a new word whenever the held one is empty or leaving
    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            result_reg <= in_result;
        end
    end

endmodule

// ----- rtl/core/wav_riff_stream_parser.sv -----
// Channel  Handshake             Word
// -------  --------------------  -----------------------------------------------
// in       in_valid / in_ready   restart, data_byte
// out      out_valid / out_ready kind, pcm_byte, chunk_end, new_rate, new_channels
// cfg      cfg_wr_en             cfg_wr_data (expected sample rate)
//
// One byte per cycle while in_ready is high; each word's result appears in the cycle after it is taken.
// The single result register behind the parser logic holds each result until it is drained.
// in_ready stays high while the result register is empty or being drained.
// Reset returns the parser to the header phase and the expected rate to 16000.
module wav_riff_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  pcm_byte,
    output logic        chunk_end,
    output logic [31:0] new_rate,
    output logic [15:0] new_channels
);
    import wrp_pkg::*;

    wrp_result_t step_result;
    wrp_result_t held_result;
    logic        accept;

    assign accept = in_valid && in_ready;

    // Parser state and per-word logic
    wrp_parse_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .restart     (restart),
        .data_byte   (data_byte),
        .result      (step_result)
    );

    // Result register
    wrp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_result  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (held_result)
    );

    assign kind         = held_result.kind;
    assign pcm_byte     = held_result.pcm_byte;
    assign chunk_end    = held_result.chunk_end;
    assign new_rate     = held_result.new_rate;
    assign new_channels = held_result.new_channels;

endmodule
